### src/jrd_pkg.sv
// shared constants and arithmetic helpers for the radial deadzone core
`default_nettype none
package jrd_pkg;

  localparam int unsigned AXIS_W    = 16;
  localparam int unsigned DZ_W      = 15;
  localparam int unsigned MAG_W     = 16;
  localparam int unsigned SUM_W     = 32;
  localparam int unsigned SQ_STEPS  = 16;
  localparam int unsigned DIV_STEPS = 17;
  localparam int unsigned QUO_W     = 17;
  // lane register stages: square, sum, root steps, prepare, divide steps
  localparam int unsigned LANE_LAT  = 2 + SQ_STEPS + 1 + DIV_STEPS;

  localparam logic [DZ_W-1:0] FULL_SCALE = 15'd32767;
  localparam logic [DZ_W-1:0] LEFT_DZ_RST  = 15'd7849;
  localparam logic [DZ_W-1:0] RIGHT_DZ_RST = 15'd8689;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_DZ  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DZ = 1'd1;

  // one restoring division step: returns {quotient bit, new remainder}
  function automatic logic [MAG_W:0] div_step(input logic [MAG_W-1:0] rem,
                                              input logic bit_in,
                                              input logic [MAG_W-1:0] dvs);
    logic [MAG_W:0] t;
    logic [MAG_W:0] d;
    t = {rem, bit_in};
    d = {1'b0, dvs};
    if (t >= d) begin
      t = t - d;
      return {1'b1, t[MAG_W-1:0]};
    end
    return {1'b0, t[MAG_W-1:0]};
  endfunction

endpackage
`default_nettype wire

### src/jrd_lane.sv
// one stick lane: magnitude, deadzone test, unit direction and pull
`default_nettype none
module jrd_lane (
  input  wire logic                          clk,
  input  wire logic                          adv,
  input  wire logic signed [jrd_pkg::AXIS_W-1:0] x,
  input  wire logic signed [jrd_pkg::AXIS_W-1:0] y,
  input  wire logic [jrd_pkg::DZ_W-1:0]      dz,
  output logic signed [jrd_pkg::AXIS_W-1:0]  dir_x,
  output logic signed [jrd_pkg::AXIS_W-1:0]  dir_y,
  output logic [jrd_pkg::AXIS_W-1:0]         pull
);
  import jrd_pkg::*;

  localparam int unsigned SB_N = SQ_STEPS + 2;

  // sideband carried through square, sum and root stages
  logic signed [AXIS_W-1:0] sx_r [SB_N];
  logic signed [AXIS_W-1:0] sy_r [SB_N];
  logic [DZ_W-1:0]          sdz_r[SB_N];

  logic [SUM_W-1:0] xx_r, yy_r;
  logic [SUM_W-1:0] n_r [SQ_STEPS+1];
  logic [SUM_W-1:0] r_r [SQ_STEPS+1];

  // division stages, index 0 is the prepare stage
  logic              dead_r [DIV_STEPS+1];
  logic              xneg_r [DIV_STEPS+1];
  logic              yneg_r [DIV_STEPS+1];
  logic              dzero_r[DIV_STEPS+1];
  logic [MAG_W-1:0]  m_r    [DIV_STEPS+1];
  logic [DZ_W-1:0]   den_r  [DIV_STEPS+1];
  logic [MAG_W-1:0]  remx_r [DIV_STEPS+1];
  logic [MAG_W-1:0]  remy_r [DIV_STEPS+1];
  logic [MAG_W-1:0]  remp_r [DIV_STEPS+1];
  logic [QUO_W-1:0]  restx_r[DIV_STEPS+1];
  logic [QUO_W-1:0]  resty_r[DIV_STEPS+1];
  logic [QUO_W-1:0]  restp_r[DIV_STEPS+1];
  logic [QUO_W-1:0]  qx_r   [DIV_STEPS+1];
  logic [QUO_W-1:0]  qy_r   [DIV_STEPS+1];
  logic [QUO_W-1:0]  qp_r   [DIV_STEPS+1];

  // prepare stage inputs
  logic [MAG_W-1:0]  mag;
  logic [AXIS_W-1:0] ax, ay;
  logic [30:0]       numx, numy;
  logic [DZ_W-1:0]   mc, diff;
  logic signed [AXIS_W-1:0] px, py;
  logic [DZ_W-1:0]   pdz;

  always_comb begin
    px   = sx_r[SB_N-1];
    py   = sy_r[SB_N-1];
    pdz  = sdz_r[SB_N-1];
    mag  = r_r[SQ_STEPS][MAG_W-1:0];
    ax   = px[AXIS_W-1] ? AXIS_W'(-px) : px;
    ay   = py[AXIS_W-1] ? AXIS_W'(-py) : py;
    numx = {ax, 15'd0};
    numy = {ay, 15'd0};
    mc   = (mag > {1'b0, FULL_SCALE}) ? FULL_SCALE : mag[DZ_W-1:0];
    diff = mc - pdz;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // squares, then sum
      xx_r <= SUM_W'(x * x);
      yy_r <= SUM_W'(y * y);
      sx_r[0] <= x;
      sy_r[0] <= y;
      sdz_r[0] <= dz;
      n_r[0] <= xx_r + yy_r;
      r_r[0] <= '0;
      for (int s = 1; s < SB_N; s++) begin
        sx_r[s]  <= sx_r[s-1];
        sy_r[s]  <= sy_r[s-1];
        sdz_r[s] <= sdz_r[s-1];
      end
      // digit-by-digit root, one digit per stage
      for (int k = 1; k <= SQ_STEPS; k++) begin
        logic [SUM_W-1:0] b;
        logic [SUM_W-1:0] rb;
        b  = SUM_W'(1) << (30 - 2*(k-1));
        rb = r_r[k-1] + b;
        if (n_r[k-1] >= rb) begin
          n_r[k] <= n_r[k-1] - rb;
          r_r[k] <= (r_r[k-1] >> 1) + b;
        end else begin
          n_r[k] <= n_r[k-1];
          r_r[k] <= r_r[k-1] >> 1;
        end
      end
      // prepare: deadzone test and dividends
      dead_r[0]  <= (mag <= {1'b0, pdz});
      xneg_r[0]  <= px[AXIS_W-1];
      yneg_r[0]  <= (py > 0);
      dzero_r[0] <= (pdz == FULL_SCALE);
      m_r[0]     <= mag;
      den_r[0]   <= FULL_SCALE - pdz;
      remx_r[0]  <= {2'b00, numx[30:17]};
      remy_r[0]  <= {2'b00, numy[30:17]};
      remp_r[0]  <= {2'b00, diff[14:1]};
      restx_r[0] <= numx[16:0];
      resty_r[0] <= numy[16:0];
      restp_r[0] <= {diff[0], 16'd0};
      qx_r[0] <= '0;
      qy_r[0] <= '0;
      qp_r[0] <= '0;
      // three restoring dividers, one quotient bit per stage
      for (int j = 1; j <= DIV_STEPS; j++) begin
        logic [MAG_W:0] tx, ty, tp;
        tx = div_step(remx_r[j-1], restx_r[j-1][QUO_W-1], m_r[j-1]);
        ty = div_step(remy_r[j-1], resty_r[j-1][QUO_W-1], m_r[j-1]);
        tp = div_step(remp_r[j-1], restp_r[j-1][QUO_W-1], {1'b0, den_r[j-1]});
        dead_r[j]  <= dead_r[j-1];
        xneg_r[j]  <= xneg_r[j-1];
        yneg_r[j]  <= yneg_r[j-1];
        dzero_r[j] <= dzero_r[j-1];
        m_r[j]     <= m_r[j-1];
        den_r[j]   <= den_r[j-1];
        remx_r[j]  <= tx[MAG_W-1:0];
        remy_r[j]  <= ty[MAG_W-1:0];
        remp_r[j]  <= tp[MAG_W-1:0];
        restx_r[j] <= restx_r[j-1] << 1;
        resty_r[j] <= resty_r[j-1] << 1;
        restp_r[j] <= restp_r[j-1] << 1;
        qx_r[j] <= {qx_r[j-1][QUO_W-2:0], tx[MAG_W]};
        qy_r[j] <= {qy_r[j-1][QUO_W-2:0], ty[MAG_W]};
        qp_r[j] <= {qp_r[j-1][QUO_W-2:0], tp[MAG_W]};
      end
    end
  end

  // sign, saturation and deadzone masking
  logic [QUO_W-1:0] fqx, fqy, fqp, nqx, nqy;
  always_comb begin
    fqx = qx_r[DIV_STEPS];
    fqy = qy_r[DIV_STEPS];
    fqp = qp_r[DIV_STEPS];
    nqx = -fqx;
    nqy = -fqy;
    if (dead_r[DIV_STEPS]) begin
      dir_x = '0;
      dir_y = '0;
      pull  = '0;
    end else begin
      if (xneg_r[DIV_STEPS]) begin
        dir_x = nqx[AXIS_W-1:0];
      end else begin
        dir_x = (fqx > 17'd32767) ? 16'sd32767 : fqx[AXIS_W-1:0];
      end
      if (yneg_r[DIV_STEPS]) begin
        dir_y = nqy[AXIS_W-1:0];
      end else begin
        dir_y = (fqy > 17'd32767) ? 16'sd32767 : fqy[AXIS_W-1:0];
      end
      if (dzero_r[DIV_STEPS] || fqp[QUO_W-1]) begin
        pull = 16'hFFFF;
      end else begin
        pull = fqp[AXIS_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

### src/joystick_radial_deadzone_core.sv
// top level: deadzone registers, two stick lanes and the merging output stage
`default_nettype none
// radial deadzone core for two thumbsticks. a word carries the left and right
// x/y readings; each stick gets its magnitude (floor square root of x*x+y*y),
// a unit direction in q1.15 with y negated, and a pull in q0.16 beyond its
// deadzone, all zero when the magnitude is at or below the deadzone. a new
// word is taken every cycle unless the pipeline holds; each word passes the
// 16 root steps and 17 divider steps of each lane. when a finished result is
// stalled the whole pipeline holds and in_stall rises. deadzones must be
// written through cfg_* while the block is idle; the block does not check it.
module joystick_radial_deadzone_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [jrd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [jrd_pkg::DZ_W-1:0]          cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [jrd_pkg::AXIS_W-1:0] in_left_x,
  input  wire logic signed [jrd_pkg::AXIS_W-1:0] in_left_y,
  input  wire logic signed [jrd_pkg::AXIS_W-1:0] in_right_x,
  input  wire logic signed [jrd_pkg::AXIS_W-1:0] in_right_y,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [jrd_pkg::AXIS_W-1:0]      out_left_dir_x,
  output logic signed [jrd_pkg::AXIS_W-1:0]      out_left_dir_y,
  output logic [jrd_pkg::AXIS_W-1:0]             out_left_pull,
  output logic signed [jrd_pkg::AXIS_W-1:0]      out_right_dir_x,
  output logic signed [jrd_pkg::AXIS_W-1:0]      out_right_dir_y,
  output logic [jrd_pkg::AXIS_W-1:0]             out_right_pull
);
  import jrd_pkg::*;

  logic [DZ_W-1:0] left_dz_r, right_dz_r;
  logic [LANE_LAT-1:0] vld_r;
  logic out_valid_r;
  logic adv;

  // pipeline moves whenever the output register is free or being taken
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign out_valid = out_valid_r;

  // deadzone registers, only the low 15 bits are kept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_dz_r  <= LEFT_DZ_RST;
      right_dz_r <= RIGHT_DZ_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEFT_DZ:  left_dz_r  <= cfg_data;
        REG_RIGHT_DZ: right_dz_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // word valid flags follow the lane stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[LANE_LAT-2:0], in_valid};
      out_valid_r <= vld_r[LANE_LAT-1];
    end
  end

  logic signed [AXIS_W-1:0] l_dx, l_dy, r_dx, r_dy;
  logic [AXIS_W-1:0] l_pull, r_pull;

  jrd_lane u_left (
    .clk   (clk),
    .adv   (adv),
    .x     (in_left_x),
    .y     (in_left_y),
    .dz    (left_dz_r),
    .dir_x (l_dx),
    .dir_y (l_dy),
    .pull  (l_pull)
  );

  jrd_lane u_right (
    .clk   (clk),
    .adv   (adv),
    .x     (in_right_x),
    .y     (in_right_y),
    .dz    (right_dz_r),
    .dir_x (r_dx),
    .dir_y (r_dy),
    .pull  (r_pull)
  );

  // merging stage: both lanes land in one result word
  always_ff @(posedge clk) begin
    if (adv) begin
      out_left_dir_x  <= l_dx;
      out_left_dir_y  <= l_dy;
      out_left_pull   <= l_pull;
      out_right_dir_x <= r_dx;
      out_right_dir_y <= r_dy;
      out_right_pull  <= r_pull;
    end
  end

endmodule
`default_nettype wire

### src/jrd_checker.sv
// port-level checks for the radial deadzone core, bound to the top level
`default_nettype none
module jrd_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic signed [jrd_pkg::AXIS_W-1:0] out_left_dir_x,
  input wire logic signed [jrd_pkg::AXIS_W-1:0] out_left_dir_y,
  input wire logic [jrd_pkg::AXIS_W-1:0]        out_left_pull,
  input wire logic signed [jrd_pkg::AXIS_W-1:0] out_right_dir_x,
  input wire logic signed [jrd_pkg::AXIS_W-1:0] out_right_dir_y,
  input wire logic [jrd_pkg::AXIS_W-1:0]        out_right_pull
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // input only stalls behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with no result waiting");

  // zero pull means the stick is inside its deadzone
  a_left_dead: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_left_pull == 16'd0 |->
      out_left_dir_x == 16'sd0 && out_left_dir_y == 16'sd0)
    else $error("left direction set with zero pull");

  a_right_dead: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_right_pull == 16'd0 |->
      out_right_dir_x == 16'sd0 && out_right_dir_y == 16'sd0)
    else $error("right direction set with zero pull");

endmodule

bind joystick_radial_deadzone_core jrd_checker u_jrd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_left_dir_x  (out_left_dir_x),
  .out_left_dir_y  (out_left_dir_y),
  .out_left_pull   (out_left_pull),
  .out_right_dir_x (out_right_dir_x),
  .out_right_dir_y (out_right_dir_y),
  .out_right_pull  (out_right_pull)
);
`default_nettype wire
